[rtl/rmae_pkg.sv]
`default_nettype none
package rmae_pkg;

	// Stream payload widths.
	localparam int S_DATA_W = 120;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 40;
	localparam int M_USER_W = 4;

	// Shared serial divider sizes.
	localparam int DIV_W = 64;
	localparam int DSR_W = 25;
	localparam int DIV_CNT_W = 6;

	// Interval floor and ms to ns scale.
	localparam logic [15:0] MIN_IVL_MS = 16'd50;
	localparam logic [19:0] NS_PER_MS = 20'd1000000;

	// Configuration register indexes.
	localparam logic [2:0] REG_ROI0 = 3'd0;
	localparam logic [2:0] REG_ROI1 = 3'd1;
	localparam logic [2:0] REG_TARGET = 3'd2;
	localparam logic [2:0] REG_DEADBAND = 3'd3;
	localparam logic [2:0] REG_GAIN = 3'd4;
	localparam logic [2:0] REG_EXP_MIN = 3'd5;
	localparam logic [2:0] REG_EXP_MAX = 3'd6;
	localparam logic [2:0] REG_INTERVAL = 3'd7;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_NOT_ALLOWED = 3'd0,
		ST_TOO_SOON    = 3'd1,
		ST_EMPTY       = 3'd2,
		ST_DEADBAND    = 3'd3,
		ST_ADJUSTED    = 3'd4,
		ST_LOADED      = 3'd5
	} status_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic    take;
		logic    tmul;
		logic    div_start;
		logic    div_sel;
		logic    mag;
		logic    emul;
		logic    pmul;
		logic    pmul_hi;
		logic    upd;
		logic    out_load;
		status_t out_status;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic in_ignore;
		logic in_load;
		logic in_last;
		logic allowed;
		logic too_soon;
		logic empty;
		logic deadband;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[rtl/rmae_div.sv]
`default_nettype none
module rmae_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rmae_pkg::DIV_W-1:0] dividend,
	input  logic [rmae_pkg::DSR_W-1:0] divisor,
	output logic [rmae_pkg::DIV_W-1:0] quotient,
	output logic                       done
);
	import rmae_pkg::*;

	logic [DSR_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DSR_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DSR_W:0]       trial;
	logic                 ge;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule
`default_nettype wire

[rtl/rmae_dp.sv]
`default_nettype none
module rmae_dp #(
	parameter int MAX_DIM     = 4096,
	parameter int NUM_CAMERAS = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rmae_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [rmae_pkg::S_USER_W-1:0] s_tuser,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rmae_pkg::M_DATA_W-1:0] m_tdata,
	output logic [rmae_pkg::M_USER_W-1:0] m_tuser,
	input  logic                          cfg_valid,
	input  logic [2:0]                    cfg_index,
	input  logic [63:0]                   cfg_data,
	input  rmae_pkg::cmd_t                cmd,
	output rmae_pkg::sts_t                sts
);
	import rmae_pkg::*;

	// Configuration registers.
	logic [63:0] roi_q [0:1];
	logic [7:0]  target_q;
	logic [7:0]  deadband_q;
	logic [15:0] gain_q;
	logic [23:0] emin_q;
	logic [23:0] emax_q;
	logic [15:0] ivl_q;

	// Per-camera state.
	logic [23:0] exp_q  [0:1];
	logic [62:0] last_q [0:1];

	// Accumulators and the latched frame-end item.
	logic [31:0] sum_q;
	logic [24:0] cnt_q;
	logic        cam_q;
	logic [62:0] ts_q;
	logic        allowed_q;
	logic        is_load_q;

	// Arithmetic registers.
	logic [35:0] md_q;
	logic [39:0] mag_q;
	logic        neg_q;
	logic [15:0] mean_q;
	logic [39:0] eg_q;
	logic [79:0] acc_q;
	logic [23:0] lo_q;
	logic [23:0] hi_q;

	logic             m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [M_USER_W-1:0] m_tuser_q;

	// Input fields.
	logic        in_cmd, in_cam, in_allowed;
	logic [7:0]  in_pix;
	logic [11:0] in_x, in_y;
	logic [62:0] in_ts;
	logic [23:0] in_load;
	assign in_cmd     = s_tuser[0];
	assign in_cam     = s_tuser[1];
	assign in_pix     = s_tdata[7:0];
	assign in_x       = s_tdata[19:8];
	assign in_y       = s_tdata[31:20];
	assign in_ts      = s_tdata[94:32];
	assign in_allowed = s_tdata[95];
	assign in_load    = s_tdata[119:96];

	// ROI membership of the incoming pixel.
	logic [63:0] roi;
	logic        in_roi, hit, ignore;
	assign roi    = roi_q[in_cam];
	assign ignore = 32'(in_cam) >= NUM_CAMERAS;
	assign in_roi = ({4'b0, in_x} >= roi[15:0])
		&& ({5'b0, in_x} < {1'b0, roi[15:0]} + {1'b0, roi[47:32]})
		&& ({4'b0, in_y} >= roi[31:16])
		&& ({5'b0, in_y} < {1'b0, roi[31:16]} + {1'b0, roi[63:48]});
	assign hit    = (32'(in_x) < MAX_DIM) && (32'(in_y) < MAX_DIM) && in_roi;

	logic [32:0] sum_add;
	assign sum_add = {1'b0, sum_q} + {25'b0, in_pix};

	// Effective target and limits.
	logic [7:0]  t_eff;
	logic [23:0] lim_a, lim_b;
	assign t_eff = (target_q == '0) ? 8'd1 : target_q;
	assign lim_a = (emin_q == '0) ? 24'd1 : emin_q;
	assign lim_b = (emax_q == '0) ? 24'd1 : emax_q;

	// Timing check against the last adjustment.
	logic [62:0] prev, diff;
	logic [15:0] ivl_eff;
	assign prev    = last_q[cam_q];
	assign diff    = ts_q - prev;
	assign ivl_eff = (ivl_q < MIN_IVL_MS) ? MIN_IVL_MS : ivl_q;

	// Divider and its operand selection.
	logic [DIV_W-1:0] div_a, div_q;
	logic [DSR_W-1:0] div_b;
	logic             div_done;
	logic [79:0]      rnd_sum;
	assign rnd_sum = acc_q + {53'b0, t_eff, 19'b0};
	always_comb begin
		if (cmd.div_sel) begin
			div_a = {4'b0, rnd_sum[79:20]};
			div_b = {17'b0, t_eff};
		end else begin
			div_a = {24'b0, sum_q, 8'b0} + {40'b0, cnt_q[24:1]};
			div_b = cnt_q;
		end
	end

	rmae_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (div_q),
		.done     (div_done)
	);

	// Mean error against the target.
	logic [39:0] mq, tq, mag;
	logic        neg;
	assign mq  = div_q[39:0];
	assign tq  = {24'b0, t_eff, 8'b0};
	assign neg = mq > tq;
	assign mag = neg ? mq - tq : tq - mq;

	// Shared partial-product multiplier.
	logic [59:0] pprod;
	assign pprod = {20'b0, eg_q} * {40'b0, (cmd.pmul_hi ? mag_q[39:20] : mag_q[19:0])};

	// Exposure update and clamp.
	logic [59:0] qv;
	logic [23:0] e_cur;
	logic [24:0] nx, nx_c;
	assign qv    = div_q[59:0];
	assign e_cur = exp_q[cam_q];
	always_comb begin
		if (neg_q)
			nx = (qv > {36'b0, e_cur}) ? {1'b0, lo_q} : {1'b0, e_cur - qv[23:0]};
		else if (|qv[59:24])
			nx = {1'b0, hi_q};
		else
			nx = {1'b0, e_cur} + {1'b0, qv[23:0]};
		nx_c = nx;
		if (nx_c < {1'b0, lo_q}) nx_c = {1'b0, lo_q};
		if (nx_c > {1'b0, hi_q}) nx_c = {1'b0, hi_q};
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_q[0]   <= '0;
			roi_q[1]   <= '0;
			target_q   <= 8'd128;
			deadband_q <= 8'd2;
			gain_q     <= 16'd2048;
			emin_q     <= 24'd10;
			emax_q     <= 24'd100000;
			ivl_q      <= 16'd200;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROI0:     roi_q[0]   <= cfg_data;
				REG_ROI1:     roi_q[1]   <= cfg_data;
				REG_TARGET:   target_q   <= cfg_data[7:0];
				REG_DEADBAND: deadband_q <= cfg_data[7:0];
				REG_GAIN:     gain_q     <= cfg_data[15:0];
				REG_EXP_MIN:  emin_q     <= cfg_data[23:0];
				REG_EXP_MAX:  emax_q     <= cfg_data[23:0];
				REG_INTERVAL: ivl_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Exposure store, adjustment times and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q[0]  <= 24'd1;
			exp_q[1]  <= 24'd1;
			last_q[0] <= '0;
			last_q[1] <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.take && !ignore) begin
				if (in_cmd)
					exp_q[in_cam] <= (in_load == '0) ? 24'd1 : in_load;
				else if (hit) begin
					sum_q <= sum_add[32] ? '1 : sum_add[31:0];
					if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.mag) last_q[cam_q] <= ts_q;
			if (cmd.upd) exp_q[cam_q] <= nx_c[23:0];
			if (cmd.out_load && !is_load_q) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	// Item latch and arithmetic stages.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cam_q     <= in_cam;
			ts_q      <= in_ts;
			allowed_q <= in_allowed;
			is_load_q <= in_cmd;
		end
		if (cmd.tmul) md_q <= {20'b0, ivl_eff} * {16'b0, NS_PER_MS};
		if (cmd.mag) begin
			mag_q  <= mag;
			neg_q  <= neg;
			mean_q <= (|mq[39:16]) ? 16'hFFFF : mq[15:0];
		end
		if (cmd.emul) begin
			eg_q <= {16'b0, e_cur} * {24'b0, gain_q};
			lo_q <= (lim_a < lim_b) ? lim_a : lim_b;
			hi_q <= (lim_a < lim_b) ? lim_b : lim_a;
		end
		if (cmd.pmul) begin
			if (cmd.pmul_hi) acc_q <= acc_q + {pprod, 20'b0};
			else             acc_q <= {20'b0, pprod};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {((cmd.out_status == ST_DEADBAND || cmd.out_status == ST_ADJUSTED)
				? mean_q : 16'd0), e_cur};
			m_tuser_q <= {cmd.out_status, cam_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Status toward the controller.
	assign sts.in_ignore = ignore;
	assign sts.in_load   = in_cmd;
	assign sts.in_last   = s_tlast;
	assign sts.allowed   = allowed_q;
	assign sts.too_soon  = (ts_q < prev) || (diff < {27'b0, md_q});
	assign sts.empty     = cnt_q == '0;
	assign sts.deadband  = mag <= {24'b0, deadband_q, 8'b0};
	assign sts.div_done  = div_done;
	assign sts.out_free  = !m_tvalid_q || m_tready;

endmodule
`default_nettype wire

[rtl/rmae_ctrl.sv]
`default_nettype none
module rmae_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output rmae_pkg::cmd_t cmd,
	input  rmae_pkg::sts_t sts
);
	import rmae_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_TMUL  = 12'b000000000010,
		S_TCMP  = 12'b000000000100,
		S_MDIV  = 12'b000000001000,
		S_MAG   = 12'b000000010000,
		S_EMUL  = 12'b000000100000,
		S_PMUL0 = 12'b000001000000,
		S_PMUL1 = 12'b000010000000,
		S_RND   = 12'b000100000000,
		S_QDIV  = 12'b001000000000,
		S_UPD   = 12'b010000000000,
		S_RES   = 12'b100000000000
	} state_t;

	state_t  state_q, state_n;
	status_t status_q, status_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_NOT_ALLOWED;
		end else begin
			state_q  <= state_n;
			status_q <= status_n;
		end
	end

	// Sequencing of the frame-end checks and the exposure update.
	always_comb begin
		state_n        = state_q;
		status_n       = status_q;
		cmd            = '0;
		cmd.out_status = status_q;
		s_tready       = state_q == S_IDLE;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (sts.in_ignore) begin
						state_n = S_IDLE;
					end else if (sts.in_load) begin
						status_n = ST_LOADED;
						state_n  = S_RES;
					end else if (sts.in_last) begin
						state_n = S_TMUL;
					end
				end
			end
			S_TMUL: begin
				cmd.tmul = 1'b1;
				if (!sts.allowed) begin
					status_n = ST_NOT_ALLOWED;
					state_n  = S_RES;
				end else begin
					state_n = S_TCMP;
				end
			end
			S_TCMP: begin
				if (sts.too_soon) begin
					status_n = ST_TOO_SOON;
					state_n  = S_RES;
				end else if (sts.empty) begin
					status_n = ST_EMPTY;
					state_n  = S_RES;
				end else begin
					cmd.div_start = 1'b1;
					state_n       = S_MDIV;
				end
			end
			S_MDIV: begin
				if (sts.div_done) state_n = S_MAG;
			end
			S_MAG: begin
				cmd.mag = 1'b1;
				if (sts.deadband) begin
					status_n = ST_DEADBAND;
					state_n  = S_RES;
				end else begin
					state_n = S_EMUL;
				end
			end
			S_EMUL: begin
				cmd.emul = 1'b1;
				state_n  = S_PMUL0;
			end
			S_PMUL0: begin
				cmd.pmul = 1'b1;
				state_n  = S_PMUL1;
			end
			S_PMUL1: begin
				cmd.pmul    = 1'b1;
				cmd.pmul_hi = 1'b1;
				state_n     = S_RND;
			end
			S_RND: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_n       = S_QDIV;
			end
			S_QDIV: begin
				cmd.div_sel = 1'b1;
				if (sts.div_done) state_n = S_UPD;
			end
			S_UPD: begin
				cmd.div_sel = 1'b1;
				cmd.upd     = 1'b1;
				status_n    = ST_ADJUSTED;
				state_n     = S_RES;
			end
			S_RES: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[rtl/roi_mean_auto_exposure.sv]
`default_nettype none
// ROI mean auto exposure controller for up to two cameras.
// Input stream s_*: one beat per pixel or per load command. tuser carries the
// command and camera, tlast marks the last pixel of a frame. Pixels that are
// not the last of a frame are taken one per cycle while the block is idle and
// add to the ROI sum when inside the ROI. The last pixel starts the frame-end
// sequence: interval check, a serial division for the Q8.8 mean, a
// partial-product multiply and a second division for the exposure step, both
// on the shared serial divider. A load command goes straight to its result.
// Output stream m_*: one beat per load command or frame end, held in an output
// register; a stalled receiver holds the result and the block waits in its
// result state before taking the next item, while plain pixels still need no
// output slot until the next frame end.
// Configuration port cfg_*: always ready; write only while the block is idle.
// Reset: registers take their default values, both exposures read 1, the
// adjustment times and the ROI accumulators are cleared.
module roi_mean_auto_exposure #(
	parameter int MAX_DIM     = 4096,
	parameter int NUM_CAMERAS = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// pixel_value, pixel_x, pixel_y, timestamp_ns, adjust_allowed, load_exposure
	input  logic [rmae_pkg::S_DATA_W-1:0] s_tdata,
	// command, camera
	input  logic [rmae_pkg::S_USER_W-1:0] s_tuser,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// exposure in microseconds, mean_level
	output logic [rmae_pkg::M_DATA_W-1:0] m_tdata,
	// result_camera, status
	output logic [rmae_pkg::M_USER_W-1:0] m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [63:0]                   cfg_data
);
	import rmae_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rmae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	rmae_dp #(
		.MAX_DIM     (MAX_DIM),
		.NUM_CAMERAS (NUM_CAMERAS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

[rtl/rmae_sva.sv]
`default_nettype none
module rmae_sva (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rmae_pkg::M_DATA_W-1:0] m_tdata,
	input logic [rmae_pkg::M_USER_W-1:0] m_tuser
);
	import rmae_pkg::*;

	// A stalled result beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Status stays within its codes.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[3:1] <= ST_LOADED)
		else $error("bad status code");

	// The exposure in effect is never zero.
	a_exp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:0] != 24'd0)
		else $error("zero exposure reported");

	// Only measured frames report a mean.
	a_mean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3:1] != ST_DEADBAND && m_tuser[3:1] != ST_ADJUSTED
		|-> m_tdata[39:24] == 16'd0)
		else $error("mean reported without measurement");

endmodule

bind roi_mean_auto_exposure rmae_sva u_sva (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

[verif/roi_mean_auto_exposure_tb.sv]
`timescale 1ns / 1ps
`default_nettype none

// Expected exposure results and their comparison against the output stream.
class exposure_scoreboard;
	logic [63:0] roi [2];
	logic [7:0]  target;
	logic [7:0]  dband;
	logic [15:0] gain;
	logic [23:0] emin;
	logic [23:0] emax;
	logic [15:0] ivl;
	logic [23:0] exposure [2];
	logic [63:0] last_adj [2];
	logic [31:0] acc_sum;
	logic [24:0] acc_cnt;
	logic [43:0] want_q [$];
	int errors;

	function new();
		roi[0] = 0; roi[1] = 0;
		target = 8'd128; dband = 8'd2; gain = 16'd2048;
		emin = 24'd10; emax = 24'd100000; ivl = 16'd200;
		exposure[0] = 1; exposure[1] = 1;
		last_adj[0] = 0; last_adj[1] = 0;
		acc_sum = 0; acc_cnt = 0;
		errors = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [63:0] v);
		case (idx)
			rmae_pkg::REG_ROI0: roi[0] = v;
			rmae_pkg::REG_ROI1: roi[1] = v;
			rmae_pkg::REG_TARGET: target = v[7:0];
			rmae_pkg::REG_DEADBAND: dband = v[7:0];
			rmae_pkg::REG_GAIN: gain = v[15:0];
			rmae_pkg::REG_EXP_MIN: emin = v[23:0];
			default: begin
				if (idx == rmae_pkg::REG_EXP_MAX) emax = v[23:0];
				else ivl = v[15:0];
			end
		endcase
	endfunction

	// Record one accepted input beat; queue a result if it makes one.
	function void note_input(logic cmd, logic cam, logic [7:0] pix, logic [11:0] px,
		logic [11:0] py, logic last, logic [62:0] ts, logic allowed, logic [23:0] load);
		logic [15:0] rx, ry, rw, rh;
		logic [63:0] min_delta, prev, tq, mq, mag, e, lo, hi, den, nxt, tgt;
		logic [127:0] q;
		logic [15:0] mean;
		rmae_pkg::status_t st;
		mean = 0;
		if (cmd) begin
			exposure[cam] = (load == 0) ? 24'd1 : load;
			want_q.push_back({cam, rmae_pkg::ST_LOADED, 16'd0, exposure[cam]});
			return;
		end
		{rh, rw, ry, rx} = roi[cam];
		if ({4'd0, px} >= rx && {20'd0, px} < {16'd0, rx} + rw
				&& {4'd0, py} >= ry && {20'd0, py} < {16'd0, ry} + rh) begin
			acc_sum = (acc_sum > 32'hFFFF_FFFF - pix) ? 32'hFFFF_FFFF : acc_sum + pix;
			if (acc_cnt != 25'h1FF_FFFF) acc_cnt++;
		end
		if (!last) return;
		min_delta = ((ivl < 50) ? 64'd50 : {48'd0, ivl}) * 64'd1000000;
		prev = last_adj[cam];
		if (!allowed) st = rmae_pkg::ST_NOT_ALLOWED;
		else if ({1'b0, ts} < prev || {1'b0, ts} - prev < min_delta)
			st = rmae_pkg::ST_TOO_SOON;
		else if (acc_cnt == 0) st = rmae_pkg::ST_EMPTY;
		else begin
			tgt = (target == 0) ? 64'd1 : {56'd0, target};
			tq = tgt << 8;
			mq = (({32'd0, acc_sum} << 8) + (acc_cnt >> 1)) / acc_cnt;
			mag = (mq > tq) ? mq - tq : tq - mq;
			mean = (mq > 64'hFFFF) ? 16'hFFFF : mq[15:0];
			last_adj[cam] = {1'b0, ts};
			if (mag <= ({56'd0, dband} << 8)) st = rmae_pkg::ST_DEADBAND;
			else begin
				e = exposure[cam];
				lo = (emin == 0) ? 1 : emin;
				hi = (emax == 0) ? 1 : emax;
				if (lo > hi) begin den = lo; lo = hi; hi = den; end
				den = tgt << 20;
				q = ({64'd0, e} * gain * mag + (den >> 1)) / den;
				if (mq > tq) nxt = (q > e) ? lo : e - q[63:0];
				else nxt = e + q[63:0];
				if (nxt < lo) nxt = lo;
				if (nxt > hi) nxt = hi;
				exposure[cam] = nxt[23:0];
				st = rmae_pkg::ST_ADJUSTED;
			end
		end
		acc_sum = 0;
		acc_cnt = 0;
		want_q.push_back({cam, st, mean, exposure[cam]});
	endfunction

	// Compare one output beat against the oldest expectation.
	function void check_result(logic [39:0] data, logic [3:0] user);
		logic [43:0] w;
		if (want_q.size() == 0) begin
			$error("unexpected result beat data=%h user=%h", data, user);
			errors++;
			return;
		end
		w = want_q.pop_front();
		if (user[0] !== w[43]) begin
			$error("result_camera expected %0d actual %0d", w[43], user[0]); errors++;
		end
		if (user[3:1] !== w[42:40]) begin
			$error("status expected %0d actual %0d", w[42:40], user[3:1]); errors++;
		end
		if (data[39:24] !== w[39:24]) begin
			$error("mean_level expected %0d actual %0d", w[39:24], data[39:24]); errors++;
		end
		if (data[23:0] !== w[23:0]) begin
			$error("exposure expected %0d actual %0d", w[23:0], data[23:0]); errors++;
		end
	endfunction
endclass

module roi_mean_auto_exposure_tb;
	import rmae_pkg::*;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [S_USER_W-1:0] s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	exposure_scoreboard board;
	int cycle_count;
	int stall_hold;
	bit calm;
	int frames_done;
	int loads_done;
	logic [62:0] clock_ns [2];

	roi_mean_auto_exposure dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: random stalls, a long hold-off when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
			if (stall_hold > 0) begin
				stall_hold <= stall_hold - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one beat, with a random gap before it unless in the calm stretch.
	task automatic send_beat(logic cmd, logic cam, logic [7:0] pix, logic [11:0] px,
		logic [11:0] py, logic last, logic [62:0] ts, logic allowed, logic [23:0] load);
		if (!calm) begin
			while ($urandom_range(99) < 7) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {load, allowed, ts, py, px, pix};
		s_tuser <= {cam, cmd};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		board.note_input(cmd, cam, pix, px, py, last, ts, allowed, load);
		if (cmd) loads_done++;
		else if (last) frames_done++;
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.want_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// One small frame on a grid; all its pixels share one timestamp, advanced per frame past the default interval.
	task automatic send_frame(logic cam, int w, int h, logic allowed, bit bright);
		logic [7:0] pv;
		clock_ns[cam] = clock_ns[cam] + 63'd300000000 + $urandom_range(100000000);
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++) begin
				pv = bright ? 8'($urandom_range(255, 180)) : 8'($urandom_range(80));
				if ($urandom_range(9) == 0) pv = 8'($urandom);
				send_beat(1'b0, cam, pv, 12'(x), 12'(y), (x == w-1 && y == h-1),
					clock_ns[cam], allowed, 24'($urandom));
			end
	endtask

	function automatic logic [63:0] rand_roi();
		return {16'($urandom_range(6)), 16'($urandom_range(6)),
			16'($urandom_range(3)), 16'($urandom_range(3))};
	endfunction

	initial begin
		board = new();
		cycle_count = 0; stall_hold = 0; calm = 0;
		frames_done = 0; loads_done = 0;
		clock_ns[0] = 0; clock_ns[1] = 0;
		arst_n = 1'b0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0; s_tlast = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: register defaults first, then every register and the corner cases.
		send_frame(1'b0, 2, 2, 1'b1, 1'b0);
		go_idle();
		write_reg(REG_ROI0, {16'd4, 16'd4, 16'd0, 16'd0});
		write_reg(REG_ROI1, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		write_reg(REG_TARGET, 64'd0);
		write_reg(REG_DEADBAND, 64'd0);
		write_reg(REG_GAIN, 64'hFFFF);
		write_reg(REG_EXP_MIN, 64'd0);
		write_reg(REG_EXP_MAX, 64'hFF_FFFF);
		write_reg(REG_INTERVAL, 64'd0);
		send_beat(1'b1, 1'b0, 8'd0, 12'd0, 12'd0, 1'b0, 63'd0, 1'b0, 24'd0);
		send_beat(1'b1, 1'b1, 8'hFF, 12'hFFF, 12'hFFF, 1'b1, '1, 1'b1, 24'hFF_FFFF);
		send_beat(1'b0, 1'b0, 8'hFF, 12'hFFF, 12'hFFF, 1'b1, 63'd5, 1'b0, 24'd1);
		send_beat(1'b0, 1'b0, 8'hFF, 12'd0, 12'd0, 1'b1, 63'd1000, 1'b1, 24'd1);
		send_beat(1'b0, 1'b1, 8'hFF, 12'hFFF, 12'hFFF, 1'b0, '1, 1'b1, 24'd1);
		send_beat(1'b0, 1'b1, 8'hFF, 12'd0, 12'd0, 1'b1, '1, 1'b1, 24'd1);
		send_beat(1'b0, 1'b1, 8'd0, 12'd1, 12'd1, 1'b1, '1, 1'b1, 24'd1);
		send_frame(1'b0, 2, 2, 1'b1, 1'b1);
		go_idle();
		write_reg(REG_ROI0, {16'd2, 16'd2, 16'd5, 16'd5});
		send_frame(1'b0, 2, 2, 1'b1, 1'b0);
		go_idle();
		write_reg(REG_TARGET, 64'd255);
		write_reg(REG_DEADBAND, 64'd255);
		write_reg(REG_INTERVAL, 64'hFFFF);
		write_reg(REG_EXP_MIN, 64'hFF_FFFF);
		write_reg(REG_EXP_MAX, 64'd1);
		send_beat(1'b0, 1'b1, 8'd7, 12'd3, 12'd3, 1'b1, 63'd7, 1'b1, 24'd1);
		send_frame(1'b1, 2, 2, 1'b1, 1'b0);
		go_idle();

		// Random phases: each with its own setting, mostly well-formed frames.
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_ROI0, rand_roi());
			write_reg(REG_ROI1, rand_roi());
			write_reg(REG_TARGET, 64'($urandom_range(255)));
			write_reg(REG_DEADBAND, 64'($urandom_range(20)));
			write_reg(REG_GAIN, 64'($urandom_range(65535)));
			write_reg(REG_EXP_MIN, 64'($urandom_range(1000)));
			write_reg(REG_EXP_MAX, 64'($urandom_range(16777215, 50000)));
			write_reg(REG_INTERVAL, 64'($urandom_range(300)));
			calm = (ph == 3);
			if (ph == 5) stall_hold = 3000;
			for (int f = 0; f < 12; f++) begin
				if ($urandom_range(4) == 0)
					send_beat(1'b1, 1'($urandom), 8'($urandom), 12'($urandom), 12'($urandom),
						1'($urandom), 63'({$urandom, $urandom}), 1'($urandom),
						24'($urandom));
				else if ($urandom_range(6) == 0)
					send_beat(1'b0, 1'($urandom), 8'($urandom), 12'($urandom), 12'($urandom),
						1'($urandom), 63'({$urandom, $urandom}), 1'($urandom),
						24'($urandom));
				else
					send_frame(1'($urandom), $urandom_range(3, 1), $urandom_range(3, 1),
						$urandom_range(9) != 0, 1'($urandom));
			end
			calm = 0;
			go_idle();
		end

		$display("Covered %0d frame ends and %0d exposure loads over many register settings.",
			frames_done, loads_done);
		if (board.errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

`default_nettype wire
